// ===== design/scp_pkg.sv =====
// Shared constants and types for the segment closest point core.
// No dependencies; imported by every module of the block.
package scp_pkg;

   // Limb width of the split multipliers.
   localparam int LIMB_BITS = 32;

   // Register stages of one split multiplier.
   localparam int MUL_LAT = 5;

   // Configuration register file.
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 32;
   localparam int PLIM_BITS = 32;
   localparam int ZLIM_BITS = 16;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam csr_idx_type CSR_PARALLEL_LIMIT = 1'b0;
   localparam csr_idx_type CSR_ZERO_LIMIT = 1'b1;

   localparam logic [PLIM_BITS-1:0] PLIM_RESET = 32'd1;
   localparam logic [ZLIM_BITS-1:0] ZLIM_RESET = 16'd1;

endpackage

// ===== design/segment_closest_point_core.sv =====
// Top level: midpoint of the closest points of two 3-D segments.
// Depends on scp_pkg, scp_mult and scp_div.
//
//  Channel | Ports                         | Direction | Transfer when
//  --------+-------------------------------+-----------+-------------------------
//  request | req_valid/req_stall, req_*    | in        | req_valid && !req_stall
//  result  | rsp_valid/rsp_stall, rsp_mid_*| out       | rsp_valid && !rsp_stall
//  csr     | csr_wen, csr_index, csr_wdata | in        | csr_wen
//
// One pair enters per cycle while the pipeline is not held; each result passes
// through three split multipliers, the divider (one register stage per
// quotient bit) and the compare stages between them.
// Reset is synchronous; it clears the valid bits and sets both limit registers to one.
// The whole pipeline holds while a result waits under rsp_stall.
module segment_closest_point_core #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COORD_BITS-1:0]   req_p0_x,
   input  logic signed [COORD_BITS-1:0]   req_p0_y,
   input  logic signed [COORD_BITS-1:0]   req_p0_z,
   input  logic signed [COORD_BITS-1:0]   req_p1_x,
   input  logic signed [COORD_BITS-1:0]   req_p1_y,
   input  logic signed [COORD_BITS-1:0]   req_p1_z,
   input  logic signed [COORD_BITS-1:0]   req_q0_x,
   input  logic signed [COORD_BITS-1:0]   req_q0_y,
   input  logic signed [COORD_BITS-1:0]   req_q0_z,
   input  logic signed [COORD_BITS-1:0]   req_q1_x,
   input  logic signed [COORD_BITS-1:0]   req_q1_y,
   input  logic signed [COORD_BITS-1:0]   req_q1_z,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [COORD_BITS-1:0]   rsp_mid_x,
   output logic signed [COORD_BITS-1:0]   rsp_mid_y,
   output logic signed [COORD_BITS-1:0]   rsp_mid_z,
   input  logic                           csr_wen,
   input  scp_pkg::csr_idx_type           csr_index,
   input  logic [scp_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import scp_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int AW = PW + 2;
   localparam int MW = 2 * AW;
   localparam int NW = MW + 1;
   localparam int QW = 2 * FRAC_BITS + 1;
   localparam int TW = QW + 1 + DW;
   localparam int SW = COORD_BITS + 2 * FRAC_BITS + 4;
   localparam int HW = SW - 2 * FRAC_BITS - 1;
   localparam int PV = 9 * DW;
   localparam int S2W = 5 * AW + PV;
   localparam int LAT = 3 * MUL_LAT + QW + 8;

   // ---------------------------------------------------------------
   // Handshake and valid bits
   // ---------------------------------------------------------------
   logic           adv;
   logic [LAT-1:0] vld_in, vld_ff;

   assign adv = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall = !adv;
   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [PLIM_BITS-1:0] plim_ff;
   logic [ZLIM_BITS-1:0] zlim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plim_ff <= PLIM_RESET;
         zlim_ff <= ZLIM_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PARALLEL_LIMIT: begin
               plim_ff <= csr_wdata[PLIM_BITS-1:0];
            end
            CSR_ZERO_LIMIT: begin
               zlim_ff <= csr_wdata[ZLIM_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Stage one: direction vectors, start-point offset and the sum of the start points
   // ---------------------------------------------------------------
   logic signed [COORD_BITS-1:0] p0_c [3], p1_c [3], q0_c [3], q1_c [3];
   logic signed [DW-1:0] u_s1_ff [3], v_s1_ff [3], w_s1_ff [3], pq_s1_ff [3];
   logic [PV-1:0] pqvu_s1;

   assign p0_c[0] = req_p0_x;
   assign p0_c[1] = req_p0_y;
   assign p0_c[2] = req_p0_z;
   assign p1_c[0] = req_p1_x;
   assign p1_c[1] = req_p1_y;
   assign p1_c[2] = req_p1_z;
   assign q0_c[0] = req_q0_x;
   assign q0_c[1] = req_q0_y;
   assign q0_c[2] = req_q0_z;
   assign q1_c[0] = req_q1_x;
   assign q1_c[1] = req_q1_y;
   assign q1_c[2] = req_q1_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            u_s1_ff[k]  <= DW'(p1_c[k]) - DW'(p0_c[k]);
            v_s1_ff[k]  <= DW'(q1_c[k]) - DW'(q0_c[k]);
            w_s1_ff[k]  <= DW'(p0_c[k]) - DW'(q0_c[k]);
            pq_s1_ff[k] <= DW'(p0_c[k]) + DW'(q0_c[k]);
         end
      end
   end

   assign pqvu_s1 = {pq_s1_ff[2], pq_s1_ff[1], pq_s1_ff[0],
                     v_s1_ff[2], v_s1_ff[1], v_s1_ff[0],
                     u_s1_ff[2], u_s1_ff[1], u_s1_ff[0]};

   // ---------------------------------------------------------------
   // Component products of the five dot products
   // ---------------------------------------------------------------
   logic signed [PW-1:0] uu_p [3], uv_p [3], vv_p [3], uw_p [3], vw_p [3];

   for (genvar k = 0; k < 3; k++) begin : g_dot
      scp_mult #(.WA(DW), .WB(DW)) u_uu (
         .clock(clock), .en(adv), .a(u_s1_ff[k]), .b(u_s1_ff[k]), .prod(uu_p[k]));
      scp_mult #(.WA(DW), .WB(DW)) u_uv (
         .clock(clock), .en(adv), .a(u_s1_ff[k]), .b(v_s1_ff[k]), .prod(uv_p[k]));
      scp_mult #(.WA(DW), .WB(DW)) u_vv (
         .clock(clock), .en(adv), .a(v_s1_ff[k]), .b(v_s1_ff[k]), .prod(vv_p[k]));
      scp_mult #(.WA(DW), .WB(DW)) u_uw (
         .clock(clock), .en(adv), .a(u_s1_ff[k]), .b(w_s1_ff[k]), .prod(uw_p[k]));
      scp_mult #(.WA(DW), .WB(DW)) u_vw (
         .clock(clock), .en(adv), .a(v_s1_ff[k]), .b(w_s1_ff[k]), .prod(vw_p[k]));
   end

   logic [PV-1:0] side1_ff [MUL_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff[0] <= pqvu_s1;
         for (int i = 1; i < MUL_LAT; i++) begin
            side1_ff[i] <= side1_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Dot product sums a to e
   // ---------------------------------------------------------------
   logic signed [AW-1:0] a_s2_ff, b_s2_ff, c_s2_ff, d_s2_ff, e_s2_ff;
   logic [PV-1:0] pqvu_s2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_s2_ff <= AW'(uu_p[0]) + AW'(uu_p[1]) + AW'(uu_p[2]);
         b_s2_ff <= AW'(uv_p[0]) + AW'(uv_p[1]) + AW'(uv_p[2]);
         c_s2_ff <= AW'(vv_p[0]) + AW'(vv_p[1]) + AW'(vv_p[2]);
         d_s2_ff <= AW'(uw_p[0]) + AW'(uw_p[1]) + AW'(uw_p[2]);
         e_s2_ff <= AW'(vw_p[0]) + AW'(vw_p[1]) + AW'(vw_p[2]);
         pqvu_s2_ff <= side1_ff[MUL_LAT-1];
      end
   end

   // ---------------------------------------------------------------
   // Second-order products for D and the two unclamped numerators
   // ---------------------------------------------------------------
   logic signed [MW-1:0] ac_p, bb_p, be_p, cd_p, ae_p, bd_p;

   scp_mult #(.WA(AW), .WB(AW)) u_ac (
      .clock(clock), .en(adv), .a(a_s2_ff), .b(c_s2_ff), .prod(ac_p));
   scp_mult #(.WA(AW), .WB(AW)) u_bb (
      .clock(clock), .en(adv), .a(b_s2_ff), .b(b_s2_ff), .prod(bb_p));
   scp_mult #(.WA(AW), .WB(AW)) u_be (
      .clock(clock), .en(adv), .a(b_s2_ff), .b(e_s2_ff), .prod(be_p));
   scp_mult #(.WA(AW), .WB(AW)) u_cd (
      .clock(clock), .en(adv), .a(c_s2_ff), .b(d_s2_ff), .prod(cd_p));
   scp_mult #(.WA(AW), .WB(AW)) u_ae (
      .clock(clock), .en(adv), .a(a_s2_ff), .b(e_s2_ff), .prod(ae_p));
   scp_mult #(.WA(AW), .WB(AW)) u_bd (
      .clock(clock), .en(adv), .a(b_s2_ff), .b(d_s2_ff), .prod(bd_p));

   logic [S2W-1:0] side2_ff [MUL_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff[0] <= {a_s2_ff, b_s2_ff, c_s2_ff, d_s2_ff, e_s2_ff, pqvu_s2_ff};
         for (int i = 1; i < MUL_LAT; i++) begin
            side2_ff[i] <= side2_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // K1: D and the unclamped numerators
   // ---------------------------------------------------------------
   logic signed [NW-1:0] dd_k1_ff, snf_k1_ff, tnf_k1_ff;
   logic signed [AW-1:0] a_k1_ff, b_k1_ff, c_k1_ff, d_k1_ff, e_k1_ff;
   logic [PV-1:0] pqvu_k1_ff;
   logic [S2W-1:0] side2_out;

   assign side2_out = side2_ff[MUL_LAT-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         dd_k1_ff  <= NW'(ac_p) - NW'(bb_p);
         snf_k1_ff <= NW'(be_p) - NW'(cd_p);
         tnf_k1_ff <= NW'(ae_p) - NW'(bd_p);
         a_k1_ff <= $signed(side2_out[PV + 4*AW +: AW]);
         b_k1_ff <= $signed(side2_out[PV + 3*AW +: AW]);
         c_k1_ff <= $signed(side2_out[PV + 2*AW +: AW]);
         d_k1_ff <= $signed(side2_out[PV + AW +: AW]);
         e_k1_ff <= $signed(side2_out[PV +: AW]);
         pqvu_k1_ff <= side2_out[PV-1:0];
      end
   end

   // ---------------------------------------------------------------
   // K2: parallel test and clamp of sc to [0,1]
   // ---------------------------------------------------------------
   logic signed [NW-1:0] plim_s;
   logic signed [NW-1:0] sn_k2_in, sd_k2_in, tn_k2_in, td_k2_in;
   logic signed [NW-1:0] sn_k2_ff, sd_k2_ff, tn_k2_ff, td_k2_ff, nd_k2_ff, xb_k2_ff;
   logic signed [AW-1:0] a_k2_ff;
   logic [PV-1:0] pqvu_k2_ff;

   assign plim_s = $signed(NW'(plim_ff));

   always_comb begin
      if (dd_k1_ff < plim_s) begin
         sn_k2_in = '0;
         sd_k2_in = NW'(1);
         tn_k2_in = NW'(e_k1_ff);
         td_k2_in = NW'(c_k1_ff);
      end else if (snf_k1_ff[NW-1]) begin
         sn_k2_in = '0;
         sd_k2_in = dd_k1_ff;
         tn_k2_in = NW'(e_k1_ff);
         td_k2_in = NW'(c_k1_ff);
      end else if (dd_k1_ff < snf_k1_ff) begin
         sn_k2_in = dd_k1_ff;
         sd_k2_in = dd_k1_ff;
         tn_k2_in = NW'(e_k1_ff) + NW'(b_k1_ff);
         td_k2_in = NW'(c_k1_ff);
      end else begin
         sn_k2_in = snf_k1_ff;
         sd_k2_in = dd_k1_ff;
         tn_k2_in = tnf_k1_ff;
         td_k2_in = dd_k1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sn_k2_ff <= sn_k2_in;
         sd_k2_ff <= sd_k2_in;
         tn_k2_ff <= tn_k2_in;
         td_k2_ff <= td_k2_in;
         nd_k2_ff <= -NW'(d_k1_ff);
         xb_k2_ff <= NW'(b_k1_ff) - NW'(d_k1_ff);
         a_k2_ff <= a_k1_ff;
         pqvu_k2_ff <= pqvu_k1_ff;
      end
   end

   // ---------------------------------------------------------------
   // K3: clamp of tc to [0,1], re-solving sc where tc moved
   // ---------------------------------------------------------------
   logic signed [NW-1:0] a_ext;
   logic signed [NW-1:0] sn_k3_in, sd_k3_in, tn_k3_in, td_k3_in;
   logic signed [NW-1:0] sn_k3_ff, sd_k3_ff, tn_k3_ff, td_k3_ff;
   logic [PV-1:0] pqvu_k3_ff;

   assign a_ext = NW'(a_k2_ff);

   always_comb begin
      sn_k3_in = sn_k2_ff;
      sd_k3_in = sd_k2_ff;
      tn_k3_in = tn_k2_ff;
      td_k3_in = td_k2_ff;
      if (tn_k2_ff[NW-1]) begin
         tn_k3_in = '0;
         if (nd_k2_ff[NW-1]) begin
            sn_k3_in = '0;
         end else if (a_ext < nd_k2_ff) begin
            sn_k3_in = sd_k2_ff;
         end else begin
            sn_k3_in = nd_k2_ff;
            sd_k3_in = a_ext;
         end
      end else if (td_k2_ff < tn_k2_ff) begin
         tn_k3_in = td_k2_ff;
         if (xb_k2_ff[NW-1]) begin
            sn_k3_in = '0;
         end else if (a_ext < xb_k2_ff) begin
            sn_k3_in = sd_k2_ff;
         end else begin
            sn_k3_in = xb_k2_ff;
            sd_k3_in = a_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sn_k3_ff <= sn_k3_in;
         sd_k3_ff <= sd_k3_in;
         tn_k3_ff <= tn_k3_in;
         td_k3_ff <= td_k3_in;
         pqvu_k3_ff <= pqvu_k2_ff;
      end
   end

   // ---------------------------------------------------------------
   // K4: zero tests; a forced zero becomes 0 / 1 for the divider
   // ---------------------------------------------------------------
   logic [NW-1:0] zlim_ext;
   logic          s_zero, t_zero;
   logic [NW-1:0] snum_k4_ff, sden_k4_ff, tnum_k4_ff, tden_k4_ff;
   logic [PV-1:0] pqvu_k4_ff;

   assign zlim_ext = NW'(zlim_ff);
   assign s_zero = sn_k3_ff[NW-1] || sd_k3_ff[NW-1] ||
                   ($unsigned(sn_k3_ff) < zlim_ext) || (sd_k3_ff == '0);
   assign t_zero = tn_k3_ff[NW-1] || td_k3_ff[NW-1] ||
                   ($unsigned(tn_k3_ff) < zlim_ext) || (td_k3_ff == '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         snum_k4_ff <= s_zero ? '0 : $unsigned(sn_k3_ff);
         sden_k4_ff <= s_zero ? NW'(1) : $unsigned(sd_k3_ff);
         tnum_k4_ff <= t_zero ? '0 : $unsigned(tn_k3_ff);
         tden_k4_ff <= t_zero ? NW'(1) : $unsigned(td_k3_ff);
         pqvu_k4_ff <= pqvu_k3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Segment parameters sc and tc in units of 2^-(2*FRAC_BITS)
   // ---------------------------------------------------------------
   logic [QW-1:0] sq, tq;

   scp_div #(.NW(NW), .QW(QW)) u_sdiv (
      .clock(clock), .en(adv), .num(snum_k4_ff), .den(sden_k4_ff), .quo(sq));
   scp_div #(.NW(NW), .QW(QW)) u_tdiv (
      .clock(clock), .en(adv), .num(tnum_k4_ff), .den(tden_k4_ff), .quo(tq));

   logic [PV-1:0] side3_ff [QW];

   always_ff @(posedge clock) begin
      if (adv) begin
         side3_ff[0] <= pqvu_k4_ff;
         for (int i = 1; i < QW; i++) begin
            side3_ff[i] <= side3_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Scaled direction vectors sc*u and tc*v
   // ---------------------------------------------------------------
   logic [PV-1:0] pqvu_dv;
   logic signed [QW:0] sq_s, tq_s;
   logic signed [DW-1:0] u_dv [3], v_dv [3];
   logic signed [TW-1:0] su_p [3], tv_p [3];

   assign pqvu_dv = side3_ff[QW-1];
   assign sq_s = $signed({1'b0, sq});
   assign tq_s = $signed({1'b0, tq});

   for (genvar k = 0; k < 3; k++) begin : g_scale
      assign u_dv[k] = $signed(pqvu_dv[k*DW +: DW]);
      assign v_dv[k] = $signed(pqvu_dv[(3+k)*DW +: DW]);

      scp_mult #(.WA(QW+1), .WB(DW)) u_su (
         .clock(clock), .en(adv), .a(sq_s), .b(u_dv[k]), .prod(su_p[k]));
      scp_mult #(.WA(QW+1), .WB(DW)) u_tv (
         .clock(clock), .en(adv), .a(tq_s), .b(v_dv[k]), .prod(tv_p[k]));
   end

   logic [3*DW-1:0] side4_ff [MUL_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         side4_ff[0] <= pqvu_dv[6*DW +: 3*DW];
         for (int i = 1; i < MUL_LAT; i++) begin
            side4_ff[i] <= side4_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Sum of both closest points plus the rounding half
   // ---------------------------------------------------------------
   logic signed [DW-1:0] pq_f [3];
   logic signed [SW-1:0] sum_f1_ff [3];

   for (genvar k = 0; k < 3; k++) begin : g_pq
      assign pq_f[k] = $signed(side4_ff[MUL_LAT-1][k*DW +: DW]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            sum_f1_ff[k] <= (SW'(pq_f[k]) <<< (2 * FRAC_BITS)) + SW'(su_p[k]) +
                            SW'(tv_p[k]) + (SW'(1) <<< (2 * FRAC_BITS));
         end
      end
   end

   // ---------------------------------------------------------------
   // Halve, drop the fraction bits and saturate into the result register
   // ---------------------------------------------------------------
   logic signed [HW-1:0]         sh [3];
   logic signed [COORD_BITS-1:0] mid_in [3];
   logic signed [COORD_BITS-1:0] mid_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sh[k] = HW'(sum_f1_ff[k] >>> (2 * FRAC_BITS + 1));
         if (sh[k][HW-1:COORD_BITS-1] != {(HW-COORD_BITS+1){sh[k][HW-1]}}) begin
            mid_in[k] = sh[k][HW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                    : {1'b0, {(COORD_BITS-1){1'b1}}};
         end else begin
            mid_in[k] = sh[k][COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            mid_ff[k] <= mid_in[k];
         end
      end
   end

   assign rsp_mid_x = mid_ff[0];
   assign rsp_mid_y = mid_ff[1];
   assign rsp_mid_z = mid_ff[2];

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------

   // The input side is held off only while a finished result waits.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a waiting result");

   // While the pipeline holds, no valid bit moves.
   a_hold_keeps_valids: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid bits moved during a hold");

   // An accepted request occupies the first stage in the next cycle.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted request missing from the first stage");

   // A held result keeps its payload until it is taken; the check covers x and y.
   a_hold_keeps_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_mid_x) && $stable(rsp_mid_y)))
      else $error("held result payload changed");

endmodule

// ===== design/scp_mult.sv =====
// Pipelined signed multiplier built from 32x32 limb products.
// Depends on scp_pkg for the limb width.
module scp_mult #(
   parameter int WA = 33,
   parameter int WB = 33
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [WA-1:0]   a,
   input  logic signed [WB-1:0]   b,
   output logic signed [WA+WB-1:0] prod
);
   import scp_pkg::*;

   localparam int NA = (WA + LIMB_BITS - 1) / LIMB_BITS;
   localparam int NB = (WB + LIMB_BITS - 1) / LIMB_BITS;
   localparam int MA = NA * LIMB_BITS;
   localparam int MB = NB * LIMB_BITS;
   localparam int RW = LIMB_BITS + MB;
   localparam int PW = WA + WB;

   logic [WA-1:0] amag_in, amag_ff;
   logic [WB-1:0] bmag_in, bmag_ff;
   logic          neg_ff [4];
   logic [MA-1:0] apad;
   logic [MB-1:0] bpad;
   logic [2*LIMB_BITS-1:0] pp_ff [NA][NB];
   logic [RW-1:0] row_in [NA];
   logic [RW-1:0] row_ff [NA];
   logic [MA+MB-1:0] sum_in;
   logic [PW-1:0] sum_ff;
   logic signed [PW-1:0] prod_in, prod_ff;

   // Stage one: magnitudes and the sign of the product.
   assign amag_in = a[WA-1] ? $unsigned(~a + 1'b1) : $unsigned(a);
   assign bmag_in = b[WB-1] ? $unsigned(~b + 1'b1) : $unsigned(b);

   assign apad = MA'(amag_ff);
   assign bpad = MB'(bmag_ff);

   // Stage three: one row of limb products for each limb of a.
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (RW'(pp_ff[i][j]) << (j * LIMB_BITS));
         end
      end
   end

   // Stage four: rows shifted into place and added.
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         sum_in = sum_in + ((MA + MB)'(row_ff[i]) << (i * LIMB_BITS));
      end
   end

   // Stage five: restore the sign.
   assign prod_in = neg_ff[3] ? -$signed(sum_ff) : $signed(sum_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         amag_ff <= amag_in;
         bmag_ff <= bmag_in;
         neg_ff[0] <= a[WA-1] ^ b[WB-1];
         for (int s = 1; s < 4; s++) begin
            neg_ff[s] <= neg_ff[s-1];
         end
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= (2*LIMB_BITS)'(apad[i*LIMB_BITS +: LIMB_BITS]) *
                              (2*LIMB_BITS)'(bpad[j*LIMB_BITS +: LIMB_BITS]);
            end
         end
         for (int i = 0; i < NA; i++) begin
            row_ff[i] <= row_in[i];
         end
         sum_ff <= sum_in[PW-1:0];
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== design/scp_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on scp_pkg; the numerator never exceeds the nonzero denominator.
module scp_div #(
   parameter int NW = 137,
   parameter int QW = 33
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [NW-1:0] den,
   output logic [QW-1:0] quo
);
   import scp_pkg::*;

   localparam int RW = NW + 1;

   logic [RW-1:0] rem_ff [QW];
   logic [NW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_step
      logic [RW-1:0] trial;
      logic [NW-1:0] dcur;
      logic [QW-1:0] qprev;
      logic          ge;
      logic [RW-1:0] rem_in;

      // The first step tests the top bit without a shift.
      if (s == 0) begin : g_first
         assign trial = RW'(num);
         assign dcur  = den;
         assign qprev = '0;
      end else begin : g_next
         assign trial = {rem_ff[s-1][RW-2:0], 1'b0};
         assign dcur  = den_ff[s-1];
         assign qprev = quo_ff[s-1];
      end

      assign ge = trial >= RW'(dcur);
      assign rem_in = ge ? (trial - RW'(dcur)) : trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= dcur;
            quo_ff[s] <= {qprev[QW-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule
